// ===== sv/cts_pkg.sv =====
package cts_pkg;

  // Fixed formats: Q16.16 words, Q.30 normalized time
  localparam int WORD_W = 32;
  localparam int FRAC_W = 16;
  localparam int U_W    = 30;
  localparam int IDX_W  = 3;

  // Division pipeline: two quotient bits per stage
  localparam int REM_W        = WORD_W + 1;
  localparam int UQ_W         = U_W + 1;
  localparam int DQ_W         = 50;
  localparam int DIV_STAGES   = DQ_W / 2;
  localparam int U_DIV_STAGES = U_W / 2;

  // Product widths
  localparam int TV_W = 48;
  localparam int W_W  = 34;
  localparam int X_W  = DQ_W;
  localparam int XL_W = 24;
  localparam int XH_W = X_W - XL_W;
  localparam int HI_W = W_W + XH_W;
  localparam int LO_W = W_W + XL_W + 1;
  localparam int F_W  = W_W + X_W;
  localparam int P_W  = F_W - U_W;
  localparam int S_W  = P_W + 3;
  localparam int NUM_TERMS = 6;

  typedef enum logic [IDX_W-1:0] {
    REG_START_TIME     = 3'd0,
    REG_START_POSITION = 3'd1,
    REG_START_VELOCITY = 3'd2,
    REG_GOAL_POSITION  = 3'd3,
    REG_GOAL_VELOCITY  = 3'd4,
    REG_END_TIME       = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    PHASE_BEFORE = 2'd0,
    PHASE_INSIDE = 2'd1,
    PHASE_AFTER  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_GOAL   = 2'd1,
    MODE_INTERP = 2'd2
  } mode_t;

  typedef struct packed {
    phase_t phase;
    mode_t  mode;
  } tag_t;

  // State carried through the divider stages
  typedef struct packed {
    tag_t                     tag;
    logic [WORD_W-1:0]        span;
    logic [REM_W-1:0]         ur;
    logic [UQ_W-1:0]          uq;
    logic [REM_W-1:0]         dr;
    logic [DQ_W-1:0]          dn;
    logic [DQ_W-1:0]          dq;
    logic signed [TV_W-1:0]   tiv;
    logic signed [TV_W-1:0]   tgv;
  } div_t;

  // State carried through the power stages
  typedef struct packed {
    tag_t                     tag;
    logic [UQ_W-1:0]          u;
    logic [UQ_W-1:0]          u2;
    logic [UQ_W-1:0]          u3;
    logic [DQ_W-1:0]          dq;
    logic signed [TV_W-1:0]   tiv;
    logic signed [TV_W-1:0]   tgv;
  } poly_t;

  // One restoring division step: {quotient bit, new remainder}
  function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] r,
                                              input logic b,
                                              input logic [WORD_W-1:0] d);
    logic [REM_W-1:0] r2;
    r2 = {r[REM_W-2:0], b};
    if (r2 >= {1'b0, d}) begin
      div_step = {1'b1, r2 - {1'b0, d}};
    end else begin
      div_step = {1'b0, r2};
    end
  endfunction

  // Clamp to the signed word range
  function automatic logic [WORD_W-1:0] sat_word(input logic signed [S_W-1:0] x);
    logic signed [S_W-1:0] mx;
    logic signed [S_W-1:0] mn;
    mx = S_W'({1'b0, {(WORD_W-1){1'b1}}});
    mn = -mx - S_W'(1);
    if (x > mx) begin
      sat_word = mx[WORD_W-1:0];
    end else if (x < mn) begin
      sat_word = mn[WORD_W-1:0];
    end else begin
      sat_word = x[WORD_W-1:0];
    end
  endfunction

endpackage

// ===== sv/cubic_trajectory_sampler_top.sv =====
// Cubic trajectory sampler. Six config registers describe one segment (start
// time/position/velocity, goal position/velocity, end time, all Q16.16); each
// sample_time item yields one position, velocity and phase item. The block is
// fully pipelined: one item per cycle while the output is not stalled, through
// 33 register stages including the input register. Most of them belong to the
// 25-stage restoring divider that forms |gp-ip|/T two quotient bits per stage;
// s/T runs alongside in its first 15 stages, then power, basis-weight, split
// multiply, shift and saturate stages follow.
// A stalled output freezes the whole pipe; no item is dropped or repeated.
// Write config only while no item is in flight.
module cubic_trajectory_sampler_top
  import cts_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [WORD_W-1:0]        cfg_data,
  input  logic                     sample_valid,
  output logic                     sample_stall,
  input  logic [WORD_W-1:0]        sample_time,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic signed [WORD_W-1:0] position,
  output logic signed [WORD_W-1:0] velocity,
  output logic [1:0]               phase
);

  // Configuration registers
  logic [WORD_W-1:0]        start_time;
  logic [WORD_W-1:0]        end_time;
  logic signed [WORD_W-1:0] start_position;
  logic signed [WORD_W-1:0] start_velocity;
  logic signed [WORD_W-1:0] goal_position;
  logic signed [WORD_W-1:0] goal_velocity;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_time     <= '0;
      end_time       <= '0;
      start_position <= '0;
      start_velocity <= '0;
      goal_position  <= '0;
      goal_velocity  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_START_TIME:     start_time     <= cfg_data;
        REG_START_POSITION: start_position <= cfg_data;
        REG_START_VELOCITY: start_velocity <= cfg_data;
        REG_GOAL_POSITION:  goal_position  <= cfg_data;
        REG_GOAL_VELOCITY:  goal_velocity  <= cfg_data;
        REG_END_TIME:       end_time       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipe advances unless a finished item is held at the output
  logic adv;
  assign adv          = !result_valid || !result_stall;
  assign sample_stall = !adv;

  // Valid bits
  logic                  v_in, v_prep, v_sq, v_cu, v_wt, v_pp, v_sum;
  logic [DIV_STAGES-1:0] v_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in         <= 1'b0;
      v_prep       <= 1'b0;
      v_div        <= '0;
      v_sq         <= 1'b0;
      v_cu         <= 1'b0;
      v_wt         <= 1'b0;
      v_pp         <= 1'b0;
      v_sum        <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      v_in         <= sample_valid;
      v_prep       <= v_in;
      v_div        <= {v_div[DIV_STAGES-2:0], v_prep};
      v_sq         <= v_div[DIV_STAGES-1];
      v_cu         <= v_sq;
      v_wt         <= v_cu;
      v_pp         <= v_wt;
      v_sum        <= v_pp;
      result_valid <= v_sum;
    end
  end

  // Payload registers
  logic [WORD_W-1:0]        t_in;
  div_t                     prep, prep_next;
  div_t                     div_q [DIV_STAGES];
  div_t                     div_next [DIV_STAGES];
  poly_t                    sq, sq_next, cu, cu_next;
  tag_t                     wt_tag, pp_tag, sum_tag;
  logic signed [W_W-1:0]    wt_w [NUM_TERMS];
  logic signed [X_W-1:0]    wt_x [NUM_TERMS];
  logic signed [W_W-1:0]    wt_w_next [NUM_TERMS];
  logic signed [X_W-1:0]    wt_x_next [NUM_TERMS];
  logic signed [HI_W-1:0]   pp_hi [NUM_TERMS];
  logic signed [LO_W-1:0]   pp_lo [NUM_TERMS];
  logic signed [P_W-1:0]    term [NUM_TERMS];
  logic signed [P_W-1:0]    term_next [NUM_TERMS];

  // Prep: phase decision, spans, divider seeds
  logic [WORD_W-1:0] s_prep;
  logic [WORD_W:0]   d_prep;
  logic [WORD_W:0]   dmag_prep;

  always_comb begin
    s_prep    = t_in - start_time;
    d_prep    = {goal_position[WORD_W-1], goal_position}
              - {start_position[WORD_W-1], start_position};
    dmag_prep = d_prep[WORD_W] ? -d_prep : d_prep;
    prep_next = '0;
    prep_next.span = end_time - start_time;
    if (t_in < start_time) begin
      prep_next.tag = '{phase: PHASE_BEFORE, mode: MODE_START};
    end else if (t_in > end_time) begin
      prep_next.tag = '{phase: PHASE_AFTER, mode: MODE_GOAL};
    end else if (end_time == start_time) begin
      prep_next.tag = '{phase: PHASE_INSIDE, mode: MODE_GOAL};
    end else begin
      prep_next.tag = '{phase: PHASE_INSIDE, mode: MODE_INTERP};
    end
    // s <= T for inside items, so the integer quotient bit is s == T
    if (s_prep == prep_next.span) begin
      prep_next.ur = '0;
      prep_next.uq = UQ_W'(1);
    end else begin
      prep_next.ur = {1'b0, s_prep};
      prep_next.uq = '0;
    end
    prep_next.dn = {1'b0, dmag_prep, {FRAC_W{1'b0}}};
  end

  // Divider stages: two steps each for |D|/T, for s/T in the early stages
  logic [REM_W:0]          stp;
  logic signed [2*WORD_W:0] piv, pgv;
  div_t                    src;

  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      src = (k == 0) ? prep : div_q[(k == 0) ? 0 : k - 1];
      div_next[k] = src;
      for (int j = 0; j < 2; j++) begin
        stp = div_step(div_next[k].dr, div_next[k].dn[DQ_W-1], src.span);
        div_next[k].dr = stp[REM_W-1:0];
        div_next[k].dn = {div_next[k].dn[DQ_W-2:0], 1'b0};
        div_next[k].dq = {div_next[k].dq[DQ_W-2:0], stp[REM_W]};
        if (k < U_DIV_STAGES) begin
          stp = div_step(div_next[k].ur, 1'b0, src.span);
          div_next[k].ur = stp[REM_W-1:0];
          div_next[k].uq = {div_next[k].uq[UQ_W-2:0], stp[REM_W]};
        end
      end
    end
    // T*v scaled back to Q16.16, floor
    piv = $signed({1'b0, prep.span}) * start_velocity;
    pgv = $signed({1'b0, prep.span}) * goal_velocity;
    div_next[0].tiv = piv[TV_W+FRAC_W-1:FRAC_W];
    div_next[0].tgv = pgv[TV_W+FRAC_W-1:FRAC_W];
  end

  // u^2 and u^3, Q.30 floor
  logic [2*UQ_W-1:0] uu, uuu;

  always_comb begin
    sq_next     = '0;
    sq_next.tag = div_q[DIV_STAGES-1].tag;
    sq_next.u   = div_q[DIV_STAGES-1].uq;
    sq_next.dq  = div_q[DIV_STAGES-1].dq;
    sq_next.tiv = div_q[DIV_STAGES-1].tiv;
    sq_next.tgv = div_q[DIV_STAGES-1].tgv;
    uu          = sq_next.u * sq_next.u;
    sq_next.u2  = uu[U_W+UQ_W-1:U_W];
    cu_next     = sq;
    uuu         = sq.u2 * sq.u;
    cu_next.u3  = uuu[U_W+UQ_W-1:U_W];
  end

  // Hermite basis weights and their operands
  localparam int E_W = W_W + 2;
  logic signed [E_W-1:0] eu, eu2, eu3, eone;
  logic signed [X_W-1:0] dval, dt;

  always_comb begin
    eu   = E_W'(cu.u);
    eu2  = E_W'(cu.u2);
    eu3  = E_W'(cu.u3);
    eone = E_W'(1) <<< U_W;
    dval = X_W'($signed({goal_position[WORD_W-1], goal_position})
                - $signed({start_position[WORD_W-1], start_position}));
    dt   = (dval < 0) ? -$signed(cu.dq) : $signed(cu.dq);
    wt_w_next[0] = W_W'(3 * eu2 - 2 * eu3);
    wt_w_next[1] = W_W'(eu3 - 2 * eu2 + eu);
    wt_w_next[2] = W_W'(eu3 - eu2);
    wt_w_next[3] = W_W'(3 * eu2 - 4 * eu + eone);
    wt_w_next[4] = W_W'(3 * eu2 - 2 * eu);
    wt_w_next[5] = W_W'(6 * eu - 6 * eu2);
    wt_x_next[0] = dval;
    wt_x_next[1] = X_W'(cu.tiv);
    wt_x_next[2] = X_W'(cu.tgv);
    wt_x_next[3] = X_W'(start_velocity);
    wt_x_next[4] = X_W'(goal_velocity);
    wt_x_next[5] = dt;
  end

  // Recombine split products, floor by 2^30
  logic signed [F_W-1:0] full [NUM_TERMS];

  always_comb begin
    for (int i = 0; i < NUM_TERMS; i++) begin
      full[i]      = $signed({pp_hi[i], {XL_W{1'b0}}}) + F_W'(pp_lo[i]);
      term_next[i] = full[i][F_W-1:U_W];
    end
  end

  // Final sums
  logic signed [S_W-1:0] pos_sum, vel_sum;

  always_comb begin
    pos_sum = S_W'(start_position) + S_W'(term[0]) + S_W'(term[1]) + S_W'(term[2]);
    vel_sum = S_W'(term[3]) + S_W'(term[4]) + S_W'(term[5]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_in   <= sample_time;
      prep   <= prep_next;
      div_q  <= div_next;
      sq     <= sq_next;
      cu     <= cu_next;
      wt_tag <= cu.tag;
      wt_w   <= wt_w_next;
      wt_x   <= wt_x_next;
      pp_tag <= wt_tag;
      for (int i = 0; i < NUM_TERMS; i++) begin
        pp_hi[i] <= wt_w[i] * $signed(wt_x[i][X_W-1:XL_W]);
        pp_lo[i] <= wt_w[i] * $signed({1'b0, wt_x[i][XL_W-1:0]});
      end
      sum_tag <= pp_tag;
      term    <= term_next;
      phase   <= sum_tag.phase;
      case (sum_tag.mode)
        MODE_START: begin
          position <= start_position;
          velocity <= start_velocity;
        end
        MODE_GOAL: begin
          position <= goal_position;
          velocity <= goal_velocity;
        end
        MODE_INTERP: begin
          position <= sat_word(pos_sum);
          velocity <= sat_word(vel_sum);
        end
        default: begin
          position <= goal_position;
          velocity <= goal_velocity;
        end
      endcase
    end
  end

  // Checks
  a_no_valid_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_phase_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (phase == PHASE_BEFORE || phase == PHASE_INSIDE ||
                      phase == PHASE_AFTER))
    else $error("phase code out of range");

  a_before_holds_start: assert property (@(posedge clk) disable iff (rst)
    (result_valid && phase == PHASE_BEFORE) |->
      (position == start_position && velocity == start_velocity))
    else $error("before-start item does not hold start values");

  a_after_holds_goal: assert property (@(posedge clk) disable iff (rst)
    (result_valid && phase == PHASE_AFTER) |->
      (position == goal_position && velocity == goal_velocity))
    else $error("after-end item does not hold goal values");

endmodule
